// ===== hw/rtl/utt_pkg.sv =====
// shared types and constants of the utf-8 to utf-16 transcoder
package utt_pkg;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam int unsigned MAX_UNITS   = 4;

    // all units caused by one input byte
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [2:0]                 count;
        logic                       eot;
    } t_run;

endpackage

// ===== hw/rtl/utt_decode.sv =====
// sequence state and per-byte decode into a run of code units
module utt_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_text,
    output utt_pkg::t_run o_run
);
    import utt_pkg::*;

    logic [7:0] r_lead, n_lead;
    logic [1:0] r_held, n_held;
    logic [1:0] r_needed, n_needed;
    logic [5:0] r_tail0, n_tail0;
    logic [5:0] r_tail1, n_tail1;

    logic [5:0]  last6;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [19:0] cp4_off;
    logic        bad2, bad3, bad4;
    logic        is_cont;

    // candidate code points for each sequence length
    assign last6   = i_data_byte[5:0];
    assign is_cont = (i_data_byte[7:6] == 2'b10);
    assign cp2     = {r_lead[4:0], last6};
    assign cp3     = {r_lead[3:0], r_tail0, last6};
    assign cp4     = {r_lead[2:0], r_tail0, r_tail1, last6};
    assign cp4_off = cp4[19:0] - 20'h10000;
    assign bad2    = (cp2[10:7] == 4'd0);
    assign bad3    = (cp3[15:11] == 5'd0) || (cp3[15:11] == 5'b11011);
    assign bad4    = (cp4[20:16] == 5'd0) || (cp4[20] && (cp4[19:16] != 4'd0));

    // next state and run of units
    always_comb begin
        n_lead   = r_lead;
        n_held   = r_held;
        n_needed = r_needed;
        n_tail0  = r_tail0;
        n_tail1  = r_tail1;
        o_run.units = {MAX_UNITS{REPLACEMENT}};
        o_run.count = 3'd0;
        o_run.eot   = i_end_of_text;

        if ((r_held != 2'd0) && (r_needed != 2'd0) && is_cont) begin
            if (r_held >= r_needed) begin
                // sequence complete
                n_lead   = 8'h00;
                n_held   = 2'd0;
                n_needed = 2'd0;
                o_run.count = 3'd1;
                case (r_needed)
                    2'd1: begin
                        if (!bad2) o_run.units[0] = {5'd0, cp2};
                    end
                    2'd2: begin
                        if (!bad3) o_run.units[0] = cp3;
                    end
                    default: begin
                        if (!bad4) begin
                            o_run.units[0] = HI_SURR | {6'd0, cp4_off[19:10]};
                            o_run.units[1] = LO_SURR | {6'd0, cp4_off[9:0]};
                            o_run.count    = 3'd2;
                        end
                    end
                endcase
            end else begin
                // hold another continuation byte
                if (r_held == 2'd1) n_tail0 = last6;
                else                n_tail1 = last6;
                n_held = r_held + 2'd1;
            end
        end else begin
            // flush whatever is open, then start from this byte
            o_run.count = {1'b0, r_held};
            n_lead   = 8'h00;
            n_held   = 2'd0;
            n_needed = 2'd0;
            if (!i_data_byte[7]) begin
                o_run.units[r_held] = {8'h00, i_data_byte};
                o_run.count = o_run.count + 3'd1;
            end else if (i_data_byte[7:5] == 3'b110) begin
                n_lead = i_data_byte; n_held = 2'd1; n_needed = 2'd1;
            end else if (i_data_byte[7:4] == 4'b1110) begin
                n_lead = i_data_byte; n_held = 2'd1; n_needed = 2'd2;
            end else if (i_data_byte[7:3] == 5'b11110) begin
                n_lead = i_data_byte; n_held = 2'd1; n_needed = 2'd3;
            end else begin
                o_run.count = o_run.count + 3'd1;
            end
        end

        // end of text flushes an open sequence
        if (i_end_of_text) begin
            o_run.count = o_run.count + {1'b0, n_held};
            n_lead   = 8'h00;
            n_held   = 2'd0;
            n_needed = 2'd0;
        end
    end

    // sequence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= 8'h00;
            r_held   <= 2'd0;
            r_needed <= 2'd0;
        end else if (i_accept) begin
            r_lead   <= n_lead;
            r_held   <= n_held;
            r_needed <= n_needed;
        end
    end

    // held continuation payloads
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tail0 <= n_tail0;
            r_tail1 <= n_tail1;
        end
    end

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// top level of the utf-8 to utf-16 transcoder
// Takes one UTF-8 byte per beat and returns UTF-16 code units, one per beat, with
// malformed input replaced by U+FFFD. A byte is decoded in the cycle it is taken
// and all units it causes (zero to four) go as one run into a two-run queue; the
// output side drains the queue one unit per cycle while i_ready is high. Bytes
// enter at one per cycle while each causes at most one unit and i_ready stays
// high; input stalls only when both queue slots hold runs.
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_last_of_run,
    output logic        o_text_done
);
    import utt_pkg::*;

    t_run       run;
    t_run       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_fill, n_fill;
    logic [1:0] r_idx;
    logic       accept, enq, deq, out_beat, last;
    t_run       head;

    assign o_ready  = (r_fill != 2'd2);
    assign accept   = i_valid && o_ready;
    assign enq      = accept && (run.count != 3'd0);
    assign head     = r_q[r_rd];
    assign o_valid  = (r_fill != 2'd0);
    assign out_beat = o_valid && i_ready;
    assign last     = ({1'b0, r_idx} == head.count - 3'd1);
    assign deq      = out_beat && last;

    utt_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_run         (run)
    );

    // output unit selection
    assign o_code_unit   = head.units[r_idx];
    assign o_last_of_run = last;
    assign o_text_done   = last && head.eot;

    // queue fill count
    always_comb begin
        n_fill = r_fill;
        if (enq && !deq)      n_fill = r_fill + 2'd1;
        else if (!enq && deq) n_fill = r_fill - 2'd1;
    end

    // queue pointers and unit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
            r_idx  <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (enq) r_wr <= ~r_wr;
            if (deq) begin
                r_rd  <= ~r_rd;
                r_idx <= 2'd0;
            end else if (out_beat) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (enq) r_q[r_wr] <= run;
    end

endmodule

// ===== test/tb_top.sv =====
// testbench for the utf-8 to utf-16 transcoder: predictor, scoreboard, stimulus and checks
`timescale 1ns / 1ps

// one expected utf-16 unit together with its run and text flags
typedef struct packed {
    logic [15:0] code;
    logic        last;
    logic        done;
} t_unit_rec;

// decodes accepted bytes into the units the transcoder owes and checks what it returns
class utf16_unit_board;
    t_unit_rec       units_due[$];
    logic [15:0]     run_units[$];
    logic [7:0]      lead = '0;
    logic [5:0]      tail [2];
    int unsigned     held;
    int unsigned     needed;
    int unsigned     mismatches;
    int unsigned     bytes_taken;
    int unsigned     units_checked;
    int unsigned     texts_ended;
    int unsigned     pairs_due;
    int unsigned     replacements_due;
    int unsigned     full_runs;

    function int pending();
        return units_due.size();
    endfunction

    // append one unit to the run of the current byte
    function void add_unit(logic [15:0] u);
        run_units.insert(run_units.size(), u);
    endfunction

    // an open sequence turns into one replacement per held byte
    function void flush_open();
        repeat (held) add_unit(utt_pkg::REPLACEMENT);
        held   = 0;
        needed = 0;
        lead   = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
        logic [20:0] cp;
        logic [20:0] offs;
        bit          bad;
        t_unit_rec   rec;
        run_units.delete();
        bytes_taken++;
        if (held != 0 && b[7:6] == 2'b10) begin
            if (held >= needed) begin
                // sequence complete: assemble the code point and screen it
                case (needed)
                    1: begin
                        cp  = {10'd0, lead[4:0], b[5:0]};
                        bad = cp < 21'h80;
                    end
                    2: begin
                        cp  = {5'd0, lead[3:0], tail[0], b[5:0]};
                        bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
                    end
                    default: begin
                        cp  = {lead[2:0], tail[0], tail[1], b[5:0]};
                        bad = cp < 21'h10000 || cp > 21'h10FFFF;
                    end
                endcase
                held   = 0;
                needed = 0;
                lead   = '0;
                if (bad) begin
                    add_unit(utt_pkg::REPLACEMENT);
                end else if (cp <= 21'hFFFF) begin
                    add_unit(cp[15:0]);
                end else begin
                    offs = cp - 21'h10000;
                    add_unit(utt_pkg::HI_SURR + {6'd0, offs[19:10]});
                    add_unit(utt_pkg::LO_SURR + {6'd0, offs[9:0]});
                    pairs_due++;
                end
            end else begin
                tail[held - 1] = b[5:0];
                held++;
            end
        end else begin
            // broken sequence gets replaced, then the byte starts afresh
            flush_open();
            if (!b[7]) begin
                add_unit({8'h00, b});
            end else if (b[7:5] == 3'b110) begin
                lead = b; held = 1; needed = 1;
            end else if (b[7:4] == 4'b1110) begin
                lead = b; held = 1; needed = 2;
            end else if (b[7:3] == 5'b11110) begin
                lead = b; held = 1; needed = 3;
            end else begin
                add_unit(utt_pkg::REPLACEMENT);
            end
        end
        // a text that ends inside a sequence flushes it
        if (eot) begin
            flush_open();
            texts_ended++;
        end
        if (run_units.size() == utt_pkg::MAX_UNITS)
            full_runs++;
        foreach (run_units[k]) begin
            if (run_units[k] == utt_pkg::REPLACEMENT)
                replacements_due++;
            rec.code = run_units[k];
            rec.last = (k == run_units.size() - 1);
            rec.done = (k == run_units.size() - 1) && eot;
            units_due.insert(units_due.size(), rec);
        end
    endfunction

    function void check_unit(logic [15:0] code, logic last, logic done);
        t_unit_rec want;
        units_checked++;
        if (units_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unit %h last %b done %b arrived with nothing expected",
                         code, last, done);
            return;
        end
        want = units_due.pop_front();
        if (want.code !== code || want.last !== last || want.done !== done) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unit %0d: expected %h last %b done %b, got %h last %b done %b",
                         units_checked, want.code, want.last, want.done, code, last, done);
        end
    endfunction
endclass

module tb_top;

    localparam int DIRECTED_LEN = 25;
    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_AT     = 300;
    localparam int CALM_LO      = 100;
    localparam int CALM_HI      = 160;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 120;

    // bit 8 marks end of text
    localparam logic [8:0] DIRECTED_TEXT [0:DIRECTED_LEN-1] = '{
        9'h000, 9'h07F,                         // ascii extremes
        9'h0C0, 9'h080,                         // overlong two-byte form
        9'h0ED, 9'h0A0, 9'h080,                 // surrogate code point
        9'h0F0, 9'h090, 9'h080, 9'h080,         // lowest surrogate pair
        9'h0F4, 9'h090, 9'h080, 9'h080,         // above 0x10ffff
        9'h080, 9'h0FF,                         // stray bytes
        9'h0E2, 9'h082, 9'h041,                 // broken three-byte sequence
        9'h0F0, 9'h090, 9'h080, 9'h1C2,         // broken and cut off: four units
        9'h141                                  // plain byte ending a text
    };

    localparam logic [20:0] EDGE_POINTS [0:7] = '{
        21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte   = '0;
    logic        i_end_of_text = 1'b0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [15:0] o_code_unit;
    logic        o_last_of_run;
    logic        o_text_done;

    utf16_unit_board sb;
    logic [7:0]      plan_byte[$];
    logic            plan_eot[$];
    int              bytes_accepted;
    longint          cycle_count = 0;

    utf8_to_utf16_transcoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_unit   (o_code_unit),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // idle stretch length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // result side: random stalls, one long hold-off, calm windows with no stalls
    initial begin : receiver
        int  hold;
        bit  long_done;
        long_done = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!long_done && bytes_accepted >= HOLD_AFTER) begin
                long_done = 1'b1;
                i_ready  <= 1'b0;
                hold      = HOLD_CYCLES;
            end else if ((cycle_count / 256) % 4 == 3) begin
                i_ready <= 1'b1;
                hold     = 1;
            end else if ($urandom_range(0, 99) < 65) begin
                i_ready <= 1'b1;
                hold     = $urandom_range(1, 8);
            end else begin
                i_ready <= 1'b0;
                hold     = idle_len();
            end
            repeat (hold) @(negedge i_clk);
        end
    end

    // check every unit taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_unit(o_code_unit, o_last_of_run, o_text_done);
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  seq[$];
        logic [7:0]  lead_b;
        logic [7:0]  b;
        logic [20:0] cp;
        int          kind;
        int          tail_len;
        int          cut;
        int          eot_at;
        bit          eot_here;
        int          gap;
        sb          = new;
        bytes_accepted = 0;

        foreach (DIRECTED_TEXT[k]) begin
            plan_byte.insert(plan_byte.size(), DIRECTED_TEXT[k][7:0]);
            plan_eot.insert(plan_eot.size(), DIRECTED_TEXT[k][8]);
        end

        // random texts: mostly well-formed sequences, plus raw leads, broken ones and noise
        while (plan_byte.size() < DIRECTED_LEN + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            seq.delete();
            if (kind < 18) begin
                seq.insert(seq.size(), 8'($urandom_range(0, 127)));
            end else if (kind < 68) begin
                case ($urandom_range(0, 3))
                    0: cp = 21'($urandom_range(32'h80, 32'h7FF));
                    1: cp = 21'($urandom_range(32'h800, 32'hFFFF));
                    2: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
                    default: cp = EDGE_POINTS[$urandom_range(0, 7)];
                endcase
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp - 21'h800;
                if (cp < 21'h800) begin
                    seq.insert(seq.size(), {3'b110, cp[10:6]});
                    seq.insert(seq.size(), {2'b10, cp[5:0]});
                end else if (cp < 21'h10000) begin
                    seq.insert(seq.size(), {4'b1110, cp[15:12]});
                    seq.insert(seq.size(), {2'b10, cp[11:6]});
                    seq.insert(seq.size(), {2'b10, cp[5:0]});
                end else begin
                    seq.insert(seq.size(), {5'b11110, cp[20:18]});
                    seq.insert(seq.size(), {2'b10, cp[17:12]});
                    seq.insert(seq.size(), {2'b10, cp[11:6]});
                    seq.insert(seq.size(), {2'b10, cp[5:0]});
                end
            end else if (kind < 92) begin
                // random payload bits: overlong, surrogate and out-of-range values show up
                tail_len = $urandom_range(1, 3);
                case (tail_len)
                    1:       lead_b = {3'b110, 5'($urandom)};
                    2:       lead_b = {4'b1110, 4'($urandom)};
                    default: lead_b = {5'b11110, 3'($urandom)};
                endcase
                seq.insert(seq.size(), lead_b);
                cut = (kind >= 84) ? $urandom_range(0, tail_len - 1) : tail_len;
                repeat (cut) seq.insert(seq.size(), {2'b10, 6'($urandom)});
                if (kind >= 84) begin
                    b = 8'($urandom);
                    if (b[7:6] == 2'b10)
                        b[6] = 1'b1;
                    seq.insert(seq.size(), b);
                end
            end else begin
                seq.insert(seq.size(), 8'($urandom));
            end
            // text ends mostly after a whole sequence, sometimes inside one
            eot_at   = seq.size() - 1;
            eot_here = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 19) == 0) begin
                eot_at   = $urandom_range(0, seq.size() - 1);
                eot_here = 1'b1;
            end
            foreach (seq[k]) begin
                plan_byte.insert(plan_byte.size(), seq[k]);
                plan_eot.insert(plan_eot.size(), eot_here && k == eot_at);
            end
        end

        // reset
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // byte side: random gaps, a calm stretch, one pause until all units are back
        foreach (plan_byte[i]) begin
            gap = (i >= CALM_LO && i < CALM_HI) ? 0 :
                  ($urandom_range(0, 1) == 0 ? 0 : idle_len());
            if (i == DRAIN_AT && gap == 0)
                gap = 1;
            if (gap > 0) begin
                i_valid <= 1'b0;
                if (i == DRAIN_AT) begin
                    while (sb.pending() != 0) @(negedge i_clk);
                end
                repeat (gap) @(negedge i_clk);
            end
            i_valid       <= 1'b1;
            i_data_byte   <= plan_byte[i];
            i_end_of_text <= plan_eot[i];
            do @(posedge i_clk); while (!o_ready);
            sb.note_byte(plan_byte[i], plan_eot[i]);
            bytes_accepted++;
            @(negedge i_clk);
        end
        i_valid <= 1'b0;

        // drain, then watch a while for stray units
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        $display("covered %0d bytes in %0d texts, %0d units checked", sb.bytes_taken,
                 sb.texts_ended, sb.units_checked);
        $display("  %0d surrogate pairs, %0d replacement units, %0d four-unit runs",
                 sb.pairs_due, sb.replacements_due, sb.full_runs);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
